FILE: sv/psr_pkg.sv
`timescale 1ns / 1ps
package psr_pkg;

    localparam int DIST_FRAC_BITS_DEF = 12;
    localparam int DIST_WIDTH_DEF     = 24;
    localparam int BASE_WIDTH         = 16;
    localparam int POS_WIDTH          = 28;
    localparam int NUM_AXES           = 3;
    localparam int AXIS_X             = 0;
    localparam int AXIS_Y             = 1;
    localparam int AXIS_Z             = 2;
    localparam int MIN_CURV_RESET     = 4;

    // register index as decoded from the word address
    localparam logic IDX_MIN_CURV = 1'b0;

    typedef struct packed {
        logic refined;
        logic neg;
    } psr_axis_stat_t;

    typedef struct packed {
        logic adv;
        logic skid_load;
        logic use_skid;
    } psr_out_ctl_t;

    function automatic int apb_data_width(input int dist_width);
        return (dist_width > 32) ? 64 : 32;
    endfunction

    function automatic int apb_addr_width(input int dist_width);
        return (dist_width > 32) ? 4 : 3;
    endfunction

endpackage

FILE: sv/psr_in_if.sv
`timescale 1ns / 1ps
interface psr_in_if #(
    parameter int DW = psr_pkg::DIST_WIDTH_DEF
);
    import psr_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [BASE_WIDTH-1:0] base_x;
    logic signed [BASE_WIDTH-1:0] base_y;
    logic signed [BASE_WIDTH-1:0] base_z;
    logic [DW-1:0]                dist_center;
    logic [DW-1:0]                dist_x_minus;
    logic [DW-1:0]                dist_x_plus;
    logic [DW-1:0]                dist_y_minus;
    logic [DW-1:0]                dist_y_plus;
    logic [DW-1:0]                dist_z_minus;
    logic [DW-1:0]                dist_z_plus;

    modport source (
        output valid, base_x, base_y, base_z, dist_center,
               dist_x_minus, dist_x_plus, dist_y_minus, dist_y_plus,
               dist_z_minus, dist_z_plus,
        input  ready
    );

    modport sink (
        input  valid, base_x, base_y, base_z, dist_center,
               dist_x_minus, dist_x_plus, dist_y_minus, dist_y_plus,
               dist_z_minus, dist_z_plus,
        output ready
    );

endinterface

FILE: sv/psr_out_if.sv
`timescale 1ns / 1ps
interface psr_out_if;
    import psr_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [POS_WIDTH-1:0] pos_x;
    logic signed [POS_WIDTH-1:0] pos_y;
    logic signed [POS_WIDTH-1:0] pos_z;
    logic                        refined_x;
    logic                        refined_y;
    logic                        refined_z;

    modport source (
        output valid, pos_x, pos_y, pos_z, refined_x, refined_y, refined_z,
        input  ready
    );

    modport sink (
        input  valid, pos_x, pos_y, pos_z, refined_x, refined_y, refined_z,
        output ready
    );

endinterface

FILE: sv/psr_cfg.sv
`timescale 1ns / 1ps
module psr_cfg #(
    parameter int DIST_WIDTH = psr_pkg::DIST_WIDTH_DEF,
    localparam int APB_DW = psr_pkg::apb_data_width(DIST_WIDTH),
    localparam int APB_AW = psr_pkg::apb_addr_width(DIST_WIDTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready,
    output logic [DIST_WIDTH-1:0] min_curv
);
    import psr_pkg::*;

    logic [DIST_WIDTH-1:0] min_curv_reg;
    logic [DIST_WIDTH-1:0] min_curv_next;
    logic                  sel_min;

    // top address bit picks the word, byte offset ignored
    assign sel_min = (paddr[APB_AW-1] == IDX_MIN_CURV);

    always_comb
    begin
        min_curv_next = min_curv_reg;
        if (psel && penable && pwrite && sel_min)
        begin
            min_curv_next = pwdata[DIST_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_curv_reg <= DIST_WIDTH'(MIN_CURV_RESET);
        end
        else
        begin
            min_curv_reg <= min_curv_next;
        end
    end

    assign prdata   = sel_min ? APB_DW'(min_curv_reg) : '0;
    assign pready   = 1'b1;
    assign min_curv = min_curv_reg;

endmodule

FILE: sv/psr_lane.sv
`timescale 1ns / 1ps
module psr_lane #(
    parameter int DIST_FRAC_BITS = psr_pkg::DIST_FRAC_BITS_DEF,
    parameter int DIST_WIDTH     = psr_pkg::DIST_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                adv,
    input  logic signed [psr_pkg::BASE_WIDTH-1:0] base,
    input  logic [DIST_WIDTH-1:0]               c,
    input  logic [DIST_WIDTH-1:0]               l,
    input  logic [DIST_WIDTH-1:0]               r,
    input  logic [DIST_WIDTH-1:0]               min_curv,
    output logic signed [psr_pkg::BASE_WIDTH-1:0] base_o,
    output logic [DIST_FRAC_BITS-2:0]           q_o,
    output psr_pkg::psr_axis_stat_t             stat_o
);
    import psr_pkg::*;

    localparam int QW = DIST_FRAC_BITS - 1;
    localparam int CW = DIST_WIDTH + 1;
    localparam int RW = DIST_WIDTH + 2;

    logic                  l_up;
    logic                  r_up;
    logic                  fit;
    logic [RW-1:0]         curv2;
    logic [DIST_WIDTH-1:0] diff;

    logic [CW-1:0]                rem_reg   [QW+1];
    logic [CW-1:0]                rem_next  [QW+1];
    logic [CW-1:0]                den_reg   [QW+1];
    logic [CW-1:0]                den_next  [QW+1];
    logic [QW-1:0]                q_reg     [QW+1];
    logic [QW-1:0]                q_next    [QW+1];
    logic signed [BASE_WIDTH-1:0] base_reg  [QW+1];
    logic signed [BASE_WIDTH-1:0] base_next [QW+1];
    psr_axis_stat_t               stat_reg  [QW+1];
    psr_axis_stat_t               stat_next [QW+1];

    // front: neighbour tests, curvature l+r-2c and |l-r|
    assign l_up  = l > c;
    assign r_up  = r > c;
    assign curv2 = {2'b00, l} + {2'b00, r} - {1'b0, c, 1'b0};
    assign fit   = l_up && r_up && (curv2 > {1'b0, min_curv, 1'b0});
    assign diff  = (l >= r) ? (l - r) : (r - l);

    assign rem_next[0]  = {1'b0, diff};
    assign den_next[0]  = curv2[CW-1:0];
    assign q_next[0]    = '0;
    assign base_next[0] = base;
    assign stat_next[0] = {fit, (l < r)};

    // restoring division, one quotient bit per stage: |l-r| * 2^(f-1) / curv2
    for (genvar k = 1; k <= QW; k = k + 1)
    begin : g_step
        logic [RW-1:0] rem2;
        logic          ge;

        assign rem2         = {rem_reg[k-1], 1'b0};
        assign ge           = rem2 >= {1'b0, den_reg[k-1]};
        assign rem_next[k]  = ge ? CW'(rem2 - {1'b0, den_reg[k-1]}) : CW'(rem2);
        assign den_next[k]  = den_reg[k-1];
        assign q_next[k]    = {q_reg[k-1][QW-2:0], ge};
        assign base_next[k] = base_reg[k-1];
        assign stat_next[k] = stat_reg[k-1];
    end

    for (genvar k = 0; k <= QW; k = k + 1)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= rem_next[k];
                den_reg[k]  <= den_next[k];
                q_reg[k]    <= q_next[k];
                base_reg[k] <= base_next[k];
                stat_reg[k] <= stat_next[k];
            end
        end
    end

    assign base_o = base_reg[QW];
    assign q_o    = q_reg[QW];
    assign stat_o = stat_reg[QW];

endmodule

FILE: sv/psr_merge.sv
`timescale 1ns / 1ps
module psr_merge #(
    parameter int DIST_FRAC_BITS = psr_pkg::DIST_FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  psr_pkg::psr_out_ctl_t                ctl,
    input  logic signed [psr_pkg::BASE_WIDTH-1:0] base [psr_pkg::NUM_AXES],
    input  logic [DIST_FRAC_BITS-2:0]            q    [psr_pkg::NUM_AXES],
    input  psr_pkg::psr_axis_stat_t              stat [psr_pkg::NUM_AXES],
    output logic signed [psr_pkg::POS_WIDTH-1:0] pos  [psr_pkg::NUM_AXES],
    output logic                                 refined [psr_pkg::NUM_AXES]
);
    import psr_pkg::*;

    logic signed [POS_WIDTH-1:0] pos_next     [NUM_AXES];
    logic signed [POS_WIDTH-1:0] mrg_pos_reg  [NUM_AXES];
    logic                        mrg_ref_reg  [NUM_AXES];
    logic signed [POS_WIDTH-1:0] skid_pos_reg [NUM_AXES];
    logic                        skid_ref_reg [NUM_AXES];

    for (genvar a = 0; a < NUM_AXES; a = a + 1)
    begin : g_axis
        logic signed [POS_WIDTH-1:0] shifted;
        logic [POS_WIDTH-1:0]        corr;

        // base moved to fixed point, wraps modulo the position width
        assign shifted = {{(POS_WIDTH-BASE_WIDTH){base[a][BASE_WIDTH-1]}}, base[a]}
                         << DIST_FRAC_BITS;
        assign corr    = POS_WIDTH'(q[a]);

        always_comb
        begin
            pos_next[a] = shifted;
            if (stat[a].refined)
            begin
                pos_next[a] = stat[a].neg ? (shifted - corr) : (shifted + corr);
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.adv)
            begin
                mrg_pos_reg[a] <= pos_next[a];
                mrg_ref_reg[a] <= stat[a].refined;
            end
            if (ctl.skid_load)
            begin
                skid_pos_reg[a] <= mrg_pos_reg[a];
                skid_ref_reg[a] <= mrg_ref_reg[a];
            end
        end

        assign pos[a]     = ctl.use_skid ? skid_pos_reg[a] : mrg_pos_reg[a];
        assign refined[a] = ctl.use_skid ? skid_ref_reg[a] : mrg_ref_reg[a];
    end

endmodule

FILE: sv/parabolic_subvoxel_peak_refine.sv
`timescale 1ns / 1ps
// channel  dir  handshake                  payload
// din      in   valid/ready                base_x/y/z, dist_center, dist_{x,y,z}_{minus,plus}
// dout     out  valid/ready                pos_x/y/z, refined_x/y/z
// apb      in   psel/penable/pwrite/pready min_curvature at word 0
//
// one item per cycle sustained while dout stays ready
// each axis lane holds a restoring divider, one quotient bit per stage
// a skid register behind the merge stage lets the pipe still take an item in the cycle in which
// dout stalls; din.ready drops in the cycle after, until the skid entry is taken
// rst_n clears the valid pipe, the skid flag and min_curvature (to 4)
module parabolic_subvoxel_peak_refine #(
    parameter int DIST_FRAC_BITS = psr_pkg::DIST_FRAC_BITS_DEF,
    parameter int DIST_WIDTH     = psr_pkg::DIST_WIDTH_DEF,
    localparam int APB_DW = psr_pkg::apb_data_width(DIST_WIDTH),
    localparam int APB_AW = psr_pkg::apb_addr_width(DIST_WIDTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    psr_in_if.sink            din,
    psr_out_if.source         dout,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);
    import psr_pkg::*;

    localparam int QW  = DIST_FRAC_BITS - 1;
    localparam int NST = QW + 2;

    logic [DIST_WIDTH-1:0] min_curv;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic           skid_vld_reg;
    logic           skid_vld_next;
    psr_out_ctl_t   ctl;

    logic signed [BASE_WIDTH-1:0] base_in   [NUM_AXES];
    logic [DIST_WIDTH-1:0]        dist_l    [NUM_AXES];
    logic [DIST_WIDTH-1:0]        dist_r    [NUM_AXES];
    logic signed [BASE_WIDTH-1:0] lane_base [NUM_AXES];
    logic [QW-1:0]                lane_q    [NUM_AXES];
    psr_axis_stat_t               lane_stat [NUM_AXES];
    logic signed [POS_WIDTH-1:0]  pos       [NUM_AXES];
    logic                         refined   [NUM_AXES];

    psr_cfg #(
        .DIST_WIDTH (DIST_WIDTH)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .min_curv (min_curv)
    );

    // pipe control: whole pipe moves unless the skid entry is occupied
    assign ctl.adv       = !skid_vld_reg;
    assign ctl.skid_load = !skid_vld_reg && vld_reg[NST-1] && !dout.ready;
    assign ctl.use_skid  = skid_vld_reg;

    always_comb
    begin
        vld_next      = vld_reg;
        skid_vld_next = skid_vld_reg;
        if (skid_vld_reg)
        begin
            if (dout.ready)
            begin
                skid_vld_next = 1'b0;
            end
        end
        else
        begin
            vld_next      = {vld_reg[NST-2:0], din.valid};
            skid_vld_next = vld_reg[NST-1] && !dout.ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg      <= vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    assign din.ready  = ctl.adv;
    assign dout.valid = skid_vld_reg || vld_reg[NST-1];

    assign base_in[AXIS_X] = din.base_x;
    assign base_in[AXIS_Y] = din.base_y;
    assign base_in[AXIS_Z] = din.base_z;
    assign dist_l[AXIS_X]  = din.dist_x_minus;
    assign dist_r[AXIS_X]  = din.dist_x_plus;
    assign dist_l[AXIS_Y]  = din.dist_y_minus;
    assign dist_r[AXIS_Y]  = din.dist_y_plus;
    assign dist_l[AXIS_Z]  = din.dist_z_minus;
    assign dist_r[AXIS_Z]  = din.dist_z_plus;

    for (genvar a = 0; a < NUM_AXES; a = a + 1)
    begin : g_lane
        psr_lane #(
            .DIST_FRAC_BITS (DIST_FRAC_BITS),
            .DIST_WIDTH     (DIST_WIDTH)
        ) u_lane (
            .clk      (clk),
            .adv      (ctl.adv),
            .base     (base_in[a]),
            .c        (din.dist_center),
            .l        (dist_l[a]),
            .r        (dist_r[a]),
            .min_curv (min_curv),
            .base_o   (lane_base[a]),
            .q_o      (lane_q[a]),
            .stat_o   (lane_stat[a])
        );
    end

    psr_merge #(
        .DIST_FRAC_BITS (DIST_FRAC_BITS)
    ) u_merge (
        .clk     (clk),
        .ctl     (ctl),
        .base    (lane_base),
        .q       (lane_q),
        .stat    (lane_stat),
        .pos     (pos),
        .refined (refined)
    );

    assign dout.pos_x     = pos[AXIS_X];
    assign dout.pos_y     = pos[AXIS_Y];
    assign dout.pos_z     = pos[AXIS_Z];
    assign dout.refined_x = refined[AXIS_X];
    assign dout.refined_y = refined[AXIS_Y];
    assign dout.refined_z = refined[AXIS_Z];

endmodule

FILE: sv/psr_chk.sv
`timescale 1ns / 1ps
module psr_chk #(
    parameter int DIST_FRAC_BITS = psr_pkg::DIST_FRAC_BITS_DEF,
    parameter int DIST_WIDTH     = psr_pkg::DIST_WIDTH_DEF,
    localparam int APB_DW = psr_pkg::apb_data_width(DIST_WIDTH),
    localparam int APB_AW = psr_pkg::apb_addr_width(DIST_WIDTH)
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [psr_pkg::POS_WIDTH-1:0] pos_x,
    input logic signed [psr_pkg::POS_WIDTH-1:0] pos_y,
    input logic signed [psr_pkg::POS_WIDTH-1:0] pos_z,
    input logic                                 refined_x,
    input logic                                 refined_y,
    input logic                                 refined_z,
    input logic                                 psel,
    input logic                                 penable,
    input logic                                 pwrite,
    input logic [APB_AW-1:0]                    paddr,
    input logic [APB_DW-1:0]                    pwdata,
    input logic [APB_DW-1:0]                    prdata,
    input logic                                 pready
);
    import psr_pkg::*;

    localparam logic [DIST_FRAC_BITS-1:0] HALF = {1'b1, {(DIST_FRAC_BITS-1){1'b0}}};

    // a stalled result holds its positions and refined_x, ordering through the skid entry included
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y)
                                    && $stable(pos_z) && $stable(refined_x))
        else $error("stalled result changed");

    // an axis left unrefined carries the base only, no fraction
    a_copy_frac: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (refined_x || pos_x[DIST_FRAC_BITS-1:0] == '0)
                   && (refined_y || pos_y[DIST_FRAC_BITS-1:0] == '0)
                   && (refined_z || pos_z[DIST_FRAC_BITS-1:0] == '0))
        else $error("unrefined axis has a fraction");

    // correction magnitude stays strictly below one half
    a_corr_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!refined_x || pos_x[DIST_FRAC_BITS-1:0] != HALF)
                   && (!refined_y || pos_y[DIST_FRAC_BITS-1:0] != HALF)
                   && (!refined_z || pos_z[DIST_FRAC_BITS-1:0] != HALF))
        else $error("correction reached one half");

    // input side only backs off after an output stall
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready))
        else $error("din.ready dropped without an output stall");

    // a written threshold reads back on the next cycle
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && paddr[APB_AW-1] == IDX_MIN_CURV
        |=> paddr[APB_AW-1] != IDX_MIN_CURV
            || prdata[DIST_WIDTH-1:0] == $past(pwdata[DIST_WIDTH-1:0]))
        else $error("min_curvature readback mismatch");

endmodule

bind parabolic_subvoxel_peak_refine psr_chk #(
    .DIST_FRAC_BITS (DIST_FRAC_BITS),
    .DIST_WIDTH     (DIST_WIDTH)
) u_psr_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .pos_x     (dout.pos_x),
    .pos_y     (dout.pos_y),
    .pos_z     (dout.pos_z),
    .refined_x (dout.refined_x),
    .refined_y (dout.refined_y),
    .refined_z (dout.refined_z),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
);
